// ===== rtl/sync_frame_deframer_fletcher8_defines.svh =====
// Assertion macros shared by the deframer RTL.
`ifndef SYNC_FRAME_DEFRAMER_FLETCHER8_DEFINES_SVH
`define SYNC_FRAME_DEFRAMER_FLETCHER8_DEFINES_SVH

// Same-cycle implication, checked on clk_i, quiet while rst_ni is low.
`define SFD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i, quiet while rst_ni is low.
`define SFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sfdf8_pkg.sv =====
// Types and constants of the sync-header deframer with Fletcher-8 checksum.
package sfdf8_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned SyncW = 24;
  localparam int unsigned EntryW = 16;
  localparam int unsigned NumEntries = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned ErrW = 2;
  localparam int unsigned StatW = 3;

  // Longest message, type byte included; table lengths above it saturate.
  localparam logic [ByteW-1:0] MaxMsgLen = 8'd255;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegSync = 3'd0;
  localparam logic [CfgIdxW-1:0] RegType0 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegType3 = 3'd4;

  // Receive error codes.
  localparam logic [ErrW-1:0] ErrNone = 2'd0;
  localparam logic [ErrW-1:0] ErrTimeout = 2'd1;

  // Frame end status.
  typedef enum logic [StatW-1:0] {
    StOk      = 3'd0,
    StTimeout = 3'd1,
    StRxErr   = 3'd2,
    StUnknown = 3'd3,
    StBadSum  = 3'd4
  } status_e;

endpackage

// ===== rtl/sync_frame_deframer_fletcher8.sv =====
// Sync-header deframer with Fletcher-8 checksum: hunt, type lookup, payload, check.
//
// Input stream (s_axis): one beat per received byte. tdata[7:0] is the byte,
// tuser[1:0] the receive error code (0 byte, 1 timeout, 2/3 other error).
// The block hunts for the three-byte sync pattern, looks the type byte up in a
// four-entry type/length table (first enabled match wins), forwards the type
// and payload bytes with their index, then compares the two trailing checksum
// bytes against the running sums A += byte, B += A (mod 256).
// Output stream (m_axis): tdata[7:0] byte, tdata[15:8] index in the message;
// tlast marks an end beat whose tuser[2:0] holds the status (0 ok, 1 timeout,
// 2 receive error, 3 unknown type, 4 checksum mismatch); tdata is 0 then.
// Not every input beat yields an output beat (sync, checksum bytes, soft errors).
// The output beat appears in the cycle after its input beat. Throughput: one beat per
// cycle while m_axis_tready is high; the per-byte update is one add chain and a compare.
// The output register decouples the sides: s_axis_tready stays high while the
// register is empty or being drained, so a stalled receiver holds only one beat.
// Reset: hunting, sync window and sums cleared, table and pattern zero, no beat
// pending. Configuration writes (cfg_we_i) take effect at the next edge and are
// expected only while the block is idle.
module sync_frame_deframer_fletcher8 (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [sfdf8_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sfdf8_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // receive stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // rx_byte
  input  logic [1:0]                      s_axis_tuser,   // rx_error
  // message stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [15:0]                     m_axis_tdata,   // out_byte, byte_index
  output logic                            m_axis_tlast,   // frame_end
  output logic [2:0]                      m_axis_tuser    // frame_status
);
  import sfdf8_pkg::*;

  typedef enum logic [1:0] {
    PhHunt    = 2'd0,
    PhType    = 2'd1,
    PhPayload = 2'd2,
    PhCheck   = 2'd3
  } phase_e;

  // configuration
  logic [SyncW-1:0]  sync_pat_q;
  logic [EntryW-1:0] type_tab_q [NumEntries];

  // frame state
  phase_e            phase_q, phase_d;
  logic [15:0]       win_q, win_d;
  logic [ByteW-1:0]  cnt_q, cnt_d;
  logic [ByteW-1:0]  len_q, len_d;
  logic [ByteW-1:0]  sum_a_q, sum_a_d;
  logic [ByteW-1:0]  sum_b_q, sum_b_d;
  logic [ByteW-1:0]  chk_a_q, chk_a_d;

  // output register
  logic              ovld_q;
  logic [15:0]       odata_q;
  logic              olast_q;
  status_e           ostat_q;

  logic              in_acc;
  logic [ByteW-1:0]  rx_b;
  logic [ErrW-1:0]   rx_err;
  status_e           err_stat;

  logic              hit;
  logic [ByteW-1:0]  hit_len;
  logic [ByteW-1:0]  msg_len;
  logic [ByteW-1:0]  a_plus, b_plus;
  logic [ByteW-1:0]  cnt_inc;

  logic              res_vld;
  logic [ByteW-1:0]  res_byte, res_idx;
  logic              fin;
  status_e           fin_stat;

  assign s_axis_tready = !ovld_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign rx_b          = s_axis_tdata;
  assign rx_err        = s_axis_tuser;
  assign err_stat      = (rx_err == ErrTimeout) ? StTimeout : StRxErr;

  // Type lookup; scan from the back so the lowest matching entry wins.
  always_comb begin
    hit     = 1'b0;
    hit_len = '0;
    for (int i = NumEntries - 1; i >= 0; i--) begin
      if ((type_tab_q[i][15:8] != '0) && (type_tab_q[i][7:0] == rx_b)) begin
        hit     = 1'b1;
        hit_len = type_tab_q[i][15:8];
      end
    end
    msg_len = (hit_len > MaxMsgLen) ? MaxMsgLen : hit_len;
  end

  // Sum update: in the type phase the sums restart from zero.
  always_comb begin
    if (phase_q == PhType) begin
      a_plus = rx_b;
      b_plus = rx_b;
    end else begin
      a_plus = sum_a_q + rx_b;
      b_plus = sum_b_q + a_plus;
    end
  end

  assign cnt_inc = cnt_q + 8'd1;

  always_comb begin
    phase_d  = phase_q;
    win_d    = win_q;
    cnt_d    = cnt_q;
    len_d    = len_q;
    sum_a_d  = sum_a_q;
    sum_b_d  = sum_b_q;
    chk_a_d  = chk_a_q;
    res_vld  = 1'b0;
    res_byte = '0;
    res_idx  = '0;
    fin      = 1'b0;
    fin_stat = StOk;

    if (in_acc) begin
      case (phase_q)
        PhHunt: begin
          if (rx_err == ErrTimeout) begin
            fin      = 1'b1;
            fin_stat = StTimeout;
          end else if (rx_err == ErrNone) begin
            // soft errors fall through untouched while hunting
            if ({win_q, rx_b} == sync_pat_q) begin
              phase_d = PhType;
              win_d   = '0;
            end else begin
              win_d = {win_q[7:0], rx_b};
            end
          end
        end
        PhType: begin
          if (rx_err != ErrNone) begin
            fin      = 1'b1;
            fin_stat = err_stat;
          end else if (!hit) begin
            fin      = 1'b1;
            fin_stat = StUnknown;
          end else begin
            len_d    = msg_len;
            sum_a_d  = a_plus;
            sum_b_d  = b_plus;
            res_vld  = 1'b1;
            res_byte = rx_b;
            if (msg_len <= 8'd1) begin
              phase_d = PhCheck;
              cnt_d   = '0;
            end else begin
              phase_d = PhPayload;
              cnt_d   = 8'd1;
            end
          end
        end
        PhPayload: begin
          if (rx_err != ErrNone) begin
            fin      = 1'b1;
            fin_stat = err_stat;
          end else begin
            sum_a_d  = a_plus;
            sum_b_d  = b_plus;
            res_vld  = 1'b1;
            res_byte = rx_b;
            res_idx  = cnt_q;
            if (cnt_inc >= len_q) begin
              phase_d = PhCheck;
              cnt_d   = '0;
            end else begin
              cnt_d = cnt_inc;
            end
          end
        end
        PhCheck: begin
          if (rx_err != ErrNone) begin
            fin      = 1'b1;
            fin_stat = err_stat;
          end else if (cnt_q == '0) begin
            chk_a_d = rx_b;
            cnt_d   = 8'd1;
          end else begin
            fin      = 1'b1;
            fin_stat = ((chk_a_q == sum_a_q) && (rx_b == sum_b_q)) ? StOk : StBadSum;
          end
        end
        default: begin
          phase_d = PhHunt;
        end
      endcase

      if (fin) begin
        phase_d  = PhHunt;
        win_d    = '0;
        cnt_d    = '0;
        res_vld  = 1'b1;
        res_byte = '0;
        res_idx  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_pat_q <= '0;
      for (int i = 0; i < NumEntries; i++) begin
        type_tab_q[i] <= '0;
      end
      phase_q <= PhHunt;
      win_q   <= '0;
      cnt_q   <= '0;
      len_q   <= '0;
      sum_a_q <= '0;
      sum_b_q <= '0;
      chk_a_q <= '0;
      ovld_q  <= 1'b0;
      odata_q <= '0;
      olast_q <= 1'b0;
      ostat_q <= StOk;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegSync) begin
          sync_pat_q <= cfg_wdata_i[SyncW-1:0];
        end else if ((cfg_idx_i >= RegType0) && (cfg_idx_i <= RegType3)) begin
          type_tab_q[2'(cfg_idx_i - RegType0)] <= cfg_wdata_i[EntryW-1:0];
        end
      end
      phase_q <= phase_d;
      win_q   <= win_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
      chk_a_q <= chk_a_d;
      if (res_vld) begin
        ovld_q  <= 1'b1;
        odata_q <= {res_idx, res_byte};
        olast_q <= fin;
        ostat_q <= fin_stat;
      end else if (m_axis_tready) begin
        ovld_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tuser  = ostat_q;

`include "sync_frame_deframer_fletcher8_defines.svh"

  `SFD_ASSERT_IMPL(a_end_zero_data, m_axis_tvalid && m_axis_tlast, m_axis_tdata == '0, "end beat carries data")
  `SFD_ASSERT_IMPL(a_data_ok_stat, m_axis_tvalid && !m_axis_tlast, m_axis_tuser == StOk, "data beat carries status")
  `SFD_ASSERT_IMPL(a_stat_range, m_axis_tvalid && m_axis_tlast, m_axis_tuser <= StBadSum, "status out of range")
  `SFD_ASSERT_IMPL(a_check_cnt, phase_q == PhCheck, cnt_q <= 8'd1, "checksum byte count runaway")
  `SFD_ASSERT_NEXT(a_err_ends, in_acc && (phase_q != PhHunt) && (rx_err != ErrNone), phase_q == PhHunt && m_axis_tvalid && m_axis_tlast, "error did not end frame")

endmodule
